// ===== design/sha_pkg.sv =====
// ----------------------------------------------------------------------------
// sha_pkg
// shared constants, round tables, sigma functions and control structs for
// the byte stream sha-256 hasher
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned ROUNDS      = 64;
  localparam logic [5:0]  LAST_BYTE   = 6'd63;
  localparam logic [5:0]  LAST_ROUND  = 6'd63;
  localparam logic [5:0]  LEN_POS     = 6'd56;
  localparam logic [7:0]  PAD_BYTE    = 8'h80;
  localparam logic [63:0] BLOCK_BITS  = 64'd512;

  localparam logic REQ_ABSORB = 1'b0;
  localparam logic REQ_FINISH = 1'b1;

  typedef struct packed {
    logic       wr;
    logic [5:0] addr;
    logic [7:0] data;
  } sched_wr_t;

  typedef struct packed {
    logic start;
    logic init;
  } comp_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } comp_stat_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    small_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    small_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] i);
    unique case (i)
      3'd0: init_h = 32'h6a09e667;
      3'd1: init_h = 32'hbb67ae85;
      3'd2: init_h = 32'h3c6ef372;
      3'd3: init_h = 32'ha54ff53a;
      3'd4: init_h = 32'h510e527f;
      3'd5: init_h = 32'h9b05688c;
      3'd6: init_h = 32'h1f83d9ab;
      default: init_h = 32'h5be0cd19;
    endcase
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] i);
    unique case (i)
      6'd0:  round_k = 32'h428a2f98;
      6'd1:  round_k = 32'h71374491;
      6'd2:  round_k = 32'hb5c0fbcf;
      6'd3:  round_k = 32'he9b5dba5;
      6'd4:  round_k = 32'h3956c25b;
      6'd5:  round_k = 32'h59f111f1;
      6'd6:  round_k = 32'h923f82a4;
      6'd7:  round_k = 32'hab1c5ed5;
      6'd8:  round_k = 32'hd807aa98;
      6'd9:  round_k = 32'h12835b01;
      6'd10: round_k = 32'h243185be;
      6'd11: round_k = 32'h550c7dc3;
      6'd12: round_k = 32'h72be5d74;
      6'd13: round_k = 32'h80deb1fe;
      6'd14: round_k = 32'h9bdc06a7;
      6'd15: round_k = 32'hc19bf174;
      6'd16: round_k = 32'he49b69c1;
      6'd17: round_k = 32'hefbe4786;
      6'd18: round_k = 32'h0fc19dc6;
      6'd19: round_k = 32'h240ca1cc;
      6'd20: round_k = 32'h2de92c6f;
      6'd21: round_k = 32'h4a7484aa;
      6'd22: round_k = 32'h5cb0a9dc;
      6'd23: round_k = 32'h76f988da;
      6'd24: round_k = 32'h983e5152;
      6'd25: round_k = 32'ha831c66d;
      6'd26: round_k = 32'hb00327c8;
      6'd27: round_k = 32'hbf597fc7;
      6'd28: round_k = 32'hc6e00bf3;
      6'd29: round_k = 32'hd5a79147;
      6'd30: round_k = 32'h06ca6351;
      6'd31: round_k = 32'h14292967;
      6'd32: round_k = 32'h27b70a85;
      6'd33: round_k = 32'h2e1b2138;
      6'd34: round_k = 32'h4d2c6dfc;
      6'd35: round_k = 32'h53380d13;
      6'd36: round_k = 32'h650a7354;
      6'd37: round_k = 32'h766a0abb;
      6'd38: round_k = 32'h81c2c92e;
      6'd39: round_k = 32'h92722c85;
      6'd40: round_k = 32'ha2bfe8a1;
      6'd41: round_k = 32'ha81a664b;
      6'd42: round_k = 32'hc24b8b70;
      6'd43: round_k = 32'hc76c51a3;
      6'd44: round_k = 32'hd192e819;
      6'd45: round_k = 32'hd6990624;
      6'd46: round_k = 32'hf40e3585;
      6'd47: round_k = 32'h106aa070;
      6'd48: round_k = 32'h19a4c116;
      6'd49: round_k = 32'h1e376c08;
      6'd50: round_k = 32'h2748774c;
      6'd51: round_k = 32'h34b0bcb5;
      6'd52: round_k = 32'h391c0cb3;
      6'd53: round_k = 32'h4ed8aa4a;
      6'd54: round_k = 32'h5b9cca4f;
      6'd55: round_k = 32'h682e6ff3;
      6'd56: round_k = 32'h748f82ee;
      6'd57: round_k = 32'h78a5636f;
      6'd58: round_k = 32'h84c87814;
      6'd59: round_k = 32'h8cc70208;
      6'd60: round_k = 32'h90befffa;
      6'd61: round_k = 32'ha4506ceb;
      6'd62: round_k = 32'hbef9a3f7;
      default: round_k = 32'hc67178f2;
    endcase
  endfunction

endpackage

// ===== design/sha_in_if.sv =====
// ----------------------------------------------------------------------------
// sha_in_if
// request channel: absorb a message byte or finish the message
// ----------------------------------------------------------------------------
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] data_byte;

  modport source (output valid, output req_type, output data_byte, input ready);
  modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface

// ===== design/sha_out_if.sv =====
// ----------------------------------------------------------------------------
// sha_out_if
// digest channel: one 32-bit digest word per beat
// ----------------------------------------------------------------------------
interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink   (input valid, input digest_word, input word_index, input last_word,
                  output ready);
endinterface

// ===== design/sha_sched.sv =====
// ----------------------------------------------------------------------------
// sha_sched
// block buffer of sixteen words that doubles as the message schedule shift line
// ----------------------------------------------------------------------------
module sha_sched (
  input  logic                clk,
  input  sha_pkg::sched_wr_t  wr,
  input  logic                step,
  output logic [31:0]         w_cur
);

  logic [15:0][31:0] w;
  logic [31:0]       w_new;

  assign w_new = w[0] + sha_pkg::small_sig0(w[1]) + w[9] + sha_pkg::small_sig1(w[14]);
  assign w_cur = w[0];

  always_ff @(posedge clk) begin
    if (step) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i + 1];
      end
      w[15] <= w_new;
    end else if (wr.wr) begin
      unique case (wr.addr[1:0])
        2'd0: w[wr.addr[5:2]][31:24] <= wr.data;
        2'd1: w[wr.addr[5:2]][23:16] <= wr.data;
        2'd2: w[wr.addr[5:2]][15:8]  <= wr.data;
        default: w[wr.addr[5:2]][7:0] <= wr.data;
      endcase
    end
  end

endmodule

// ===== design/sha_round.sv =====
// ----------------------------------------------------------------------------
// sha_round
// hash state, working variables and the shared round unit, one round a cycle
// ----------------------------------------------------------------------------
module sha_round (
  input  logic                clk,
  input  logic                rst,
  input  sha_pkg::comp_ctrl_t ctrl,
  input  logic [31:0]         w_cur,
  output sha_pkg::comp_stat_t stat,
  output logic [7:0][31:0]    hash_q
);

  logic [7:0][31:0] hash;
  logic [7:0][31:0] v;
  logic [7:0][31:0] v_next;
  logic [5:0]       cnt;
  logic             busy;
  logic             fin;
  logic [31:0]      t1;
  logic [31:0]      t2;
  logic [31:0]      ch;
  logic [31:0]      maj;

  always_comb begin
    ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
    maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t1  = v[7] + sha_pkg::big_sig1(v[4]) + ch + sha_pkg::round_k(cnt) + w_cur;
    t2  = sha_pkg::big_sig0(v[0]) + maj;
    v_next[7] = v[6];
    v_next[6] = v[5];
    v_next[5] = v[4];
    v_next[4] = v[3] + t1;
    v_next[3] = v[2];
    v_next[2] = v[1];
    v_next[1] = v[0];
    v_next[0] = t1 + t2;
  end

  assign stat.busy = busy;
  assign stat.done = fin;
  assign hash_q    = hash;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) begin
        hash[i] <= sha_pkg::init_h(3'(i));
      end
      busy <= 1'b0;
      fin  <= 1'b0;
      cnt  <= 6'd0;
    end else begin
      if (ctrl.init) begin
        for (int i = 0; i < 8; i++) begin
          hash[i] <= sha_pkg::init_h(3'(i));
        end
      end else if (fin) begin
        for (int i = 0; i < 8; i++) begin
          hash[i] <= hash[i] + v[i];
        end
      end
      fin <= 1'b0;
      if (ctrl.start) begin
        v    <= hash;
        busy <= 1'b1;
        cnt  <= 6'd0;
      end else if (busy) begin
        v   <= v_next;
        cnt <= cnt + 6'd1;
        if (cnt == sha_pkg::LAST_ROUND) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== design/sha256_byte_stream_hasher_unit.sv =====
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_unit
// streaming sha-256: bytes in, eight digest words out per message
// ----------------------------------------------------------------------------
// msg carries one request per beat: req_type 0 absorbs data_byte, req_type 1
// ends the message. digest returns the hash as eight beats, word_index 0 to 7,
// most significant word first, last_word set on the eighth.
// an absorb beat writes its byte into the block; the 64th byte of a block starts the
// compression, which holds msg not ready while it runs the 64 rounds through the
// single round unit and adds the result into the hash, so no new byte is taken
// until that block is through.
// a finish beat writes the padding one byte a cycle up to the end of the
// block, compresses, and when 56 or more bytes were held repeats this for a
// second block. the digest is then copied into an output buffer, the hash
// returns to its initial value and msg is ready for the next message while
// the digest beats drain. a stalled digest channel holds the words; a second
// finish waits for the buffer to empty before its copy.
// reset (rst, synchronous) loads the initial hash, empties the block and
// drops digest valid.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_unit (
  input  logic         clk,
  input  logic         rst,
  sha_in_if.sink       msg,
  sha_out_if.source    digest
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PAD   = 3'd1;
  localparam logic [2:0] ST_COMP  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;

  logic [2:0]          state;
  logic [6:0]          fill;
  logic [63:0]         msg_bits;
  logic [63:0]         len;
  logic                padding;
  logic                len_fits;
  logic                out_busy;
  logic [2:0]          idx;
  logic [7:0][31:0]    dig;
  logic                in_acc;
  logic [7:0]          pad_byte;
  logic [31:0]         w_cur;
  logic [7:0][31:0]    hash_q;
  sha_pkg::sched_wr_t  wr;
  sha_pkg::comp_ctrl_t ctrl;
  sha_pkg::comp_stat_t stat;

  assign msg.ready = (state == ST_IDLE);
  assign in_acc    = msg.valid && msg.ready;
  assign pad_byte  = (fill[5:0] >= sha_pkg::LEN_POS && len_fits) ? len[63:56] : 8'h00;

  always_comb begin
    wr   = '0;
    ctrl = '0;
    if (state == ST_IDLE && in_acc) begin
      wr.wr   = 1'b1;
      wr.addr = fill[5:0];
      wr.data = (msg.req_type == sha_pkg::REQ_FINISH) ? sha_pkg::PAD_BYTE : msg.data_byte;
      ctrl.start = (msg.req_type == sha_pkg::REQ_ABSORB) && (fill[5:0] == sha_pkg::LAST_BYTE);
    end else if (state == ST_PAD) begin
      if (fill[6]) begin
        ctrl.start = 1'b1;
      end else begin
        wr.wr   = 1'b1;
        wr.addr = fill[5:0];
        wr.data = pad_byte;
      end
    end else if (state == ST_DRAIN && !out_busy) begin
      ctrl.init = 1'b1;
    end
  end

  sha_sched u_sched (
    .clk   (clk),
    .wr    (wr),
    .step  (stat.busy),
    .w_cur (w_cur)
  );

  sha_round u_round (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .w_cur  (w_cur),
    .stat   (stat),
    .hash_q (hash_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      fill     <= 7'd0;
      msg_bits <= 64'd0;
      padding  <= 1'b0;
      len_fits <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (msg.req_type == sha_pkg::REQ_FINISH) begin
              len      <= msg_bits + {54'd0, fill, 3'd0};
              fill     <= fill + 7'd1;
              len_fits <= (fill[5:0] < sha_pkg::LEN_POS);
              padding  <= 1'b1;
              state    <= ST_PAD;
            end else if (ctrl.start) begin
              fill     <= 7'd0;
              msg_bits <= msg_bits + sha_pkg::BLOCK_BITS;
              padding  <= 1'b0;
              state    <= ST_COMP;
            end else begin
              fill <= fill + 7'd1;
            end
          end
        end
        ST_PAD: begin
          if (fill[6]) begin
            fill  <= 7'd0;
            state <= ST_COMP;
          end else begin
            if (fill[5:0] >= sha_pkg::LEN_POS && len_fits) begin
              len <= {len[55:0], 8'h00};
            end
            fill <= fill + 7'd1;
          end
        end
        ST_COMP: begin
          if (stat.done) begin
            if (!padding) begin
              state <= ST_IDLE;
            end else if (len_fits) begin
              state <= ST_DRAIN;
            end else begin
              len_fits <= 1'b1;
              state    <= ST_PAD;
            end
          end
        end
        ST_DRAIN: begin
          if (!out_busy) begin
            msg_bits <= 64'd0;
            fill     <= 7'd0;
            padding  <= 1'b0;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // digest output buffer
  always_ff @(posedge clk) begin
    if (ctrl.init) begin
      dig <= hash_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_busy <= 1'b0;
      idx      <= 3'd0;
    end else if (ctrl.init) begin
      out_busy <= 1'b1;
      idx      <= 3'd0;
    end else if (digest.valid && digest.ready) begin
      idx <= idx + 3'd1;
      if (idx == 3'd7) begin
        out_busy <= 1'b0;
      end
    end
  end

  assign digest.valid       = out_busy;
  assign digest.digest_word = dig[idx];
  assign digest.word_index  = idx;
  assign digest.last_word   = (idx == 3'd7);

`ifndef ASSERT_OFF
  a_no_beat_in_rounds: assert property (@(posedge clk) disable iff (rst)
    stat.busy |-> !msg.ready)
    else $error("request beat open while rounds run");

  a_start_when_free: assert property (@(posedge clk) disable iff (rst)
    ctrl.start |-> (!stat.busy && !stat.done))
    else $error("compression started while round unit in use");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill[6] |-> (fill[5:0] == 6'd0))
    else $error("block fill beyond one block");

  a_last_beat_ends: assert property (@(posedge clk) disable iff (rst)
    (digest.valid && digest.ready && digest.last_word) |=> !digest.valid)
    else $error("digest valid after last word");

  a_init_clears: assert property (@(posedge clk) disable iff (rst)
    ctrl.init |=> (fill == 7'd0 && msg_bits == 64'd0 && digest.valid))
    else $error("message state not cleared after digest copy");
`endif

endmodule
